[rtl/atip_pkg.sv]
// Shared types and constants for the attitude time interpolator.
`default_nettype none
package atip_pkg;
	localparam int DEPTH  = 1024;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int ANG_W  = 17;
	localparam int OUT_W  = 13;
	localparam int PROD_W = 51;           // 33-bit unsigned dt times 18-bit signed delta
	localparam int MAG_W  = PROD_W - 1;
	localparam int QBITS  = 17;           // quotient magnitude bits
	localparam int STEP_W = $clog2(QBITS);
	// divide by 10: floor(m / 10) == (m * ceil(2^20 / 10)) >> 20 for every m below 2^18
	localparam int RECIP_W      = 2 * ANG_W;
	localparam int TENTHS_SHIFT = 20;
	localparam logic [ANG_W-1:0] TENTHS_RECIP = 17'd104858;
	localparam logic signed [17:0] OUT_MIN = -18'sd4096;
	localparam logic signed [17:0] OUT_MAX = 18'sd4095;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	localparam logic [1:0] AX_ROLL  = 2'd0;
	localparam logic [1:0] AX_PITCH = 2'd1;
	localparam logic [1:0] AX_YAW   = 2'd2;

	typedef struct packed {
		logic [31:0]             t;
		logic signed [ANG_W-1:0] roll;
		logic signed [ANG_W-1:0] pitch;
		logic signed [ANG_W-1:0] yaw;
	} rec_t;

	typedef struct packed {
		logic             latch;
		logic             wr;
		logic [IDX_W-1:0] waddr;
		logic [IDX_W-1:0] raddr;
		logic             cap_a;
		logic             cap_b;
		logic             mul;
		logic             load_val;
		logic             add;
		logic             div_start;
		logic             store;
		logic [1:0]       axis;
		logic             emit;
		logic [1:0]       emit_status;
	} cmd_t;

	typedef struct packed {
		logic op;
		logic le;
		logic ge;
		logic lt;
		logic bracket_ok;
		logic div_done;
	} sts_t;
endpackage
`default_nettype wire

[rtl/atip_div.sv]
// Restoring serial divider, one quotient bit per cycle, sign-magnitude.
`default_nettype none
module atip_div (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	input  wire logic [atip_pkg::MAG_W-1:0] dividend,
	input  wire logic [31:0]              divisor,
	input  wire logic                     neg,
	output logic                          done,
	output logic signed [atip_pkg::QBITS:0] quot
);
	logic                          run_q, done_q, neg_q;
	logic [atip_pkg::STEP_W-1:0]   step_q;
	logic [atip_pkg::MAG_W-1:0]    rem_q;
	logic [31:0]                   dsor_q;
	logic [atip_pkg::QBITS-1:0]    qt_q;
	logic [atip_pkg::MAG_W-1:0]    shifted;
	logic                          fits;

	assign shifted = {{(atip_pkg::MAG_W-32){1'b0}}, dsor_q} << step_q;
	assign fits    = rem_q >= shifted;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q  <= 1'b1;
				step_q <= atip_pkg::STEP_W'(atip_pkg::QBITS - 1);
			end else if (run_q) begin
				if (step_q == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= dividend;
			dsor_q <= divisor;
			neg_q  <= neg;
			qt_q   <= '0;
		end else if (run_q) begin
			if (fits) rem_q <= rem_q - shifted;
			qt_q <= {qt_q[atip_pkg::QBITS-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = neg_q ? -$signed({1'b0, qt_q}) : $signed({1'b0, qt_q});
endmodule
`default_nettype wire

[rtl/atip_dp.sv]
// Datapath: record memory, bracket registers, multiplier, divider and result registers.
`default_nettype none
module atip_dp (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire atip_pkg::cmd_t                 cmd,
	output atip_pkg::sts_t                      sts,
	input  wire logic                           op,
	input  wire logic [31:0]                    time_ms,
	input  wire logic signed [atip_pkg::ANG_W-1:0] roll_in,
	input  wire logic signed [atip_pkg::ANG_W-1:0] pitch_in,
	input  wire logic signed [atip_pkg::ANG_W-1:0] yaw_in,
	output logic                                strobe,
	output logic signed [atip_pkg::OUT_W-1:0]  roll_ddeg,
	output logic signed [atip_pkg::OUT_W-1:0]  pitch_ddeg,
	output logic signed [atip_pkg::OUT_W-1:0]  yaw_ddeg,
	output logic [1:0]                          status
);
	localparam logic signed [atip_pkg::QBITS:0] OUT_MIN_EXT = atip_pkg::OUT_MIN;
	localparam logic signed [atip_pkg::QBITS:0] OUT_MAX_EXT = atip_pkg::OUT_MAX;

	atip_pkg::rec_t mem [atip_pkg::DEPTH];
	atip_pkg::rec_t in_q, rdata_q, rec_a_q, rec_b_q;
	logic           op_q;
	logic signed [atip_pkg::PROD_W-1:0] prod_q;
	logic signed [atip_pkg::QBITS+1:0]  val_q;
	logic signed [atip_pkg::OUT_W-1:0]  res_q [3];
	logic           strobe_q;
	logic [1:0]     status_q;

	logic signed [atip_pkg::ANG_W-1:0] lo_ang, hi_ang;
	logic signed [atip_pkg::ANG_W:0]   dv;
	logic [31:0]    dt, span;
	logic [atip_pkg::MAG_W-1:0] prod_mag;
	logic [atip_pkg::ANG_W-1:0] val_mag;
	logic [atip_pkg::RECIP_W-1:0] recip_prod;
	logic [atip_pkg::QBITS:0]   tenths_mag;
	logic signed [atip_pkg::QBITS:0] tenths;
	logic           div_done;
	logic signed [atip_pkg::QBITS:0] quot;
	logic signed [atip_pkg::PROD_W-1:0] prod_neg;
	logic signed [atip_pkg::QBITS+1:0]  val_neg;
	logic signed [atip_pkg::OUT_W-1:0]  sat;

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q        <= op;
			in_q.t      <= time_ms;
			in_q.roll   <= roll_in;
			in_q.pitch  <= pitch_in;
			in_q.yaw    <= yaw_in;
		end
		if (cmd.wr) mem[cmd.waddr] <= in_q;
		rdata_q <= mem[cmd.raddr];
		if (cmd.cap_a) rec_a_q <= rdata_q;
		if (cmd.cap_b) rec_b_q <= rdata_q;
		if (cmd.mul) prod_q <= $signed({1'b0, dt}) * dv;
		if (cmd.load_val) val_q <= (atip_pkg::QBITS+2)'(lo_ang);
		else if (cmd.add) val_q <= (atip_pkg::QBITS+2)'(lo_ang) + (atip_pkg::QBITS+2)'(quot);
		if (cmd.latch) begin
			res_q[0] <= '0;
			res_q[1] <= '0;
			res_q[2] <= '0;
		end else if (cmd.store) begin
			res_q[cmd.axis] <= sat;
		end
		if (cmd.emit) status_q <= cmd.emit_status;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) strobe_q <= 1'b0;
		else         strobe_q <= cmd.emit;
	end

	always_comb begin
		unique case (cmd.axis)
			atip_pkg::AX_ROLL:  begin lo_ang = rec_a_q.roll;  hi_ang = rec_b_q.roll;  end
			atip_pkg::AX_PITCH: begin lo_ang = rec_a_q.pitch; hi_ang = rec_b_q.pitch; end
			default:            begin lo_ang = rec_a_q.yaw;   hi_ang = rec_b_q.yaw;   end
		endcase
	end

	assign dv       = (atip_pkg::ANG_W+1)'(hi_ang) - (atip_pkg::ANG_W+1)'(lo_ang);
	assign dt       = in_q.t - rec_a_q.t;
	assign span     = rec_b_q.t - rec_a_q.t;
	assign prod_neg = -prod_q;
	assign prod_mag = prod_q[atip_pkg::PROD_W-1] ? prod_neg[atip_pkg::MAG_W-1:0]
	                                             : prod_q[atip_pkg::MAG_W-1:0];

	// val stays between the two bracketing angles, so its magnitude fits 17 bits
	assign val_neg    = -val_q;
	assign val_mag    = val_q[atip_pkg::QBITS+1] ? val_neg[atip_pkg::ANG_W-1:0]
	                                             : val_q[atip_pkg::ANG_W-1:0];
	assign recip_prod = val_mag * atip_pkg::TENTHS_RECIP;
	assign tenths_mag = (atip_pkg::QBITS+1)'(
		recip_prod[atip_pkg::RECIP_W-1:atip_pkg::TENTHS_SHIFT]);
	assign tenths     = val_q[atip_pkg::QBITS+1] ? -$signed(tenths_mag) : $signed(tenths_mag);

	atip_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (prod_mag),
		.divisor  (span),
		.neg      (prod_q[atip_pkg::PROD_W-1]),
		.done     (div_done),
		.quot     (quot)
	);

	always_comb begin
		if (tenths < OUT_MIN_EXT)      sat = atip_pkg::OUT_W'(atip_pkg::OUT_MIN);
		else if (tenths > OUT_MAX_EXT) sat = atip_pkg::OUT_W'(atip_pkg::OUT_MAX);
		else                           sat = tenths[atip_pkg::OUT_W-1:0];
	end

	assign sts.op         = op_q;
	assign sts.le         = in_q.t <= rdata_q.t;
	assign sts.ge         = in_q.t >= rdata_q.t;
	assign sts.lt         = in_q.t <  rdata_q.t;
	assign sts.bracket_ok = (rec_a_q.t <= in_q.t) && (in_q.t < rec_b_q.t);
	assign sts.div_done   = div_done;

	assign strobe     = strobe_q;
	assign status     = status_q;
	assign roll_ddeg  = res_q[0];
	assign pitch_ddeg = res_q[1];
	assign yaw_ddeg   = res_q[2];
endmodule
`default_nettype wire

[rtl/atip_ctrl.sv]
// Controller: record count, binary search bounds and per-axis sequencing.
`default_nettype none
module atip_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	output logic                busy,
	output atip_pkg::cmd_t      cmd,
	input  wire atip_pkg::sts_t sts
);
	typedef enum logic [4:0] {
		S_IDLE, S_DISP, S_CK0, S_CKL, S_SRCH, S_SRCHCK, S_CAPE, S_CAPA, S_CKB, S_CHK,
		S_AXIS, S_DIV1S, S_DIV1W, S_ADD, S_STORE
	} state_t;

	state_t state_q;
	logic [atip_pkg::CNT_W-1:0] count_q, lo_q, hi_q, mid_q, mid, last;
	logic [1:0] axis_q;
	logic       interp_q;

	assign last = count_q - 1'b1;
	assign mid  = lo_q + ((hi_q - lo_q) >> 1);
	assign busy = state_q != S_IDLE;

	always_comb begin
		cmd             = '0;
		cmd.latch       = (state_q == S_IDLE) && start;
		cmd.waddr       = count_q[atip_pkg::IDX_W-1:0];
		cmd.axis        = axis_q;
		cmd.emit_status = atip_pkg::ST_OK;
		unique case (state_q)
			S_DISP: begin
				if (!sts.op) begin
					cmd.emit = 1'b1;
					if (count_q == atip_pkg::CNT_W'(atip_pkg::DEPTH))
						cmd.emit_status = atip_pkg::ST_FULL;
					else
						cmd.wr = 1'b1;
				end else if (count_q == '0) begin
					cmd.emit        = 1'b1;
					cmd.emit_status = atip_pkg::ST_EMPTY;
				end
			end
			S_CK0: begin
				cmd.cap_a = sts.le;
				cmd.raddr = last[atip_pkg::IDX_W-1:0];
			end
			S_CKL: cmd.cap_a = sts.ge;
			S_SRCH: begin
				if (lo_q < hi_q)        cmd.raddr = mid[atip_pkg::IDX_W-1:0];
				else if (lo_q == '0)    cmd.raddr = '0;
				else if (lo_q >= count_q) cmd.raddr = last[atip_pkg::IDX_W-1:0];
				else                    cmd.raddr = atip_pkg::IDX_W'(lo_q - 1'b1);
			end
			S_CAPE: cmd.cap_a = 1'b1;
			S_CAPA: begin
				cmd.cap_a = 1'b1;
				cmd.raddr = lo_q[atip_pkg::IDX_W-1:0];
			end
			S_CKB: cmd.cap_b = 1'b1;
			S_AXIS: begin
				cmd.mul      = interp_q;
				cmd.load_val = !interp_q;
			end
			S_DIV1S: cmd.div_start = 1'b1;
			S_ADD:   cmd.add = 1'b1;
			S_STORE: begin
				cmd.store = 1'b1;
				cmd.emit  = axis_q == atip_pkg::AX_YAW;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			lo_q     <= '0;
			hi_q     <= '0;
			mid_q    <= '0;
			axis_q   <= atip_pkg::AX_ROLL;
			interp_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: if (start) state_q <= S_DISP;
				S_DISP: begin
					if (!sts.op) begin
						if (count_q != atip_pkg::CNT_W'(atip_pkg::DEPTH)) count_q <= count_q + 1'b1;
						state_q <= S_IDLE;
					end else if (count_q == '0) begin
						state_q <= S_IDLE;
					end else begin
						state_q <= S_CK0;
					end
					axis_q   <= atip_pkg::AX_ROLL;
					interp_q <= 1'b0;
				end
				S_CK0: state_q <= sts.le ? S_AXIS : S_CKL;
				S_CKL: begin
					lo_q    <= '0;
					hi_q    <= count_q;
					state_q <= sts.ge ? S_AXIS : S_SRCH;
				end
				S_SRCH: begin
					mid_q <= mid;
					if (lo_q < hi_q)                           state_q <= S_SRCHCK;
					else if (lo_q == '0 || lo_q >= count_q)    state_q <= S_CAPE;
					else                                       state_q <= S_CAPA;
				end
				S_SRCHCK: begin
					if (sts.lt) hi_q <= mid_q;
					else        lo_q <= mid_q + 1'b1;
					state_q <= S_SRCH;
				end
				S_CAPE: state_q <= S_AXIS;
				S_CAPA: state_q <= S_CKB;
				S_CKB:  state_q <= S_CHK;
				S_CHK: begin
					interp_q <= sts.bracket_ok;
					state_q  <= S_AXIS;
				end
				S_AXIS:  state_q <= interp_q ? S_DIV1S : S_STORE;
				S_DIV1S: state_q <= S_DIV1W;
				S_DIV1W: if (sts.div_done) state_q <= S_ADD;
				S_ADD:   state_q <= S_STORE;
				S_STORE: begin
					if (axis_q == atip_pkg::AX_YAW) begin
						state_q <= S_IDLE;
					end else begin
						axis_q  <= axis_q + 1'b1;
						state_q <= S_AXIS;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

[rtl/attitude_time_interpolator.sv]
// Top level of the attitude time interpolator.
//  channel   signals                                        direction
//  request   start, busy, op, time_ms, roll_in..yaw_in      in (accepted on start && !busy)
//  result    strobe, roll_ddeg..yaw_ddeg, status            out (one cycle, no back pressure)
// busy spans the accept to the result for a load or empty query, a query at or below the first
// record and one at or above the last; strobe follows in the cycle after busy ends.
// An interpolated query adds a binary search of at most 11 steps and, once per axis, the
// 17-step serial divider.
// Reset clears the record count and control state; the record memory is not cleared.
// busy drops in the strobe cycle; results cannot be stalled.
`default_nettype none
module attitude_time_interpolator (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        op,
	input  wire logic [31:0] time_ms,
	input  wire logic signed [16:0] roll_in,
	input  wire logic signed [16:0] pitch_in,
	input  wire logic signed [16:0] yaw_in,
	output logic             strobe,
	output logic signed [12:0] roll_ddeg,
	output logic signed [12:0] pitch_ddeg,
	output logic signed [12:0] yaw_ddeg,
	output logic [1:0]       status
);
	atip_pkg::cmd_t cmd;
	atip_pkg::sts_t sts;

	atip_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.sts    (sts)
	);

	atip_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.op         (op),
		.time_ms    (time_ms),
		.roll_in    (roll_in),
		.pitch_in   (pitch_in),
		.yaw_in     (yaw_in),
		.strobe     (strobe),
		.roll_ddeg  (roll_ddeg),
		.pitch_ddeg (pitch_ddeg),
		.yaw_ddeg   (yaw_ddeg),
		.status     (status)
	);

	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(busy)) else $error("result without a request in flight");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("accepted request did not raise busy");
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && status != atip_pkg::ST_OK |->
		roll_ddeg == '0 && pitch_ddeg == '0 && yaw_ddeg == '0)
		else $error("error result carries nonzero angles");
endmodule
`default_nettype wire

[bench/tb.sv]
// Self-checking testbench for the attitude time interpolator.
`default_nettype none
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef struct {
		logic signed [12:0] roll;
		logic signed [12:0] pitch;
		logic signed [12:0] yaw;
		logic [1:0]         status;
	} attitude_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic op = OP_LOAD;
	logic [31:0] time_ms = '0;
	logic signed [16:0] roll_in = '0, pitch_in = '0, yaw_in = '0;
	logic busy, strobe;
	logic signed [12:0] roll_ddeg, pitch_ddeg, yaw_ddeg;
	logic [1:0] status;

	attitude_time_interpolator dut (
		.clk, .arst_n, .start, .busy, .op, .time_ms, .roll_in, .pitch_in, .yaw_in,
		.strobe, .roll_ddeg, .pitch_ddeg, .yaw_ddeg, .status
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// mirror of the record table
	logic [31:0] rec_time [atip_pkg::DEPTH];
	int          rec_roll [atip_pkg::DEPTH], rec_pitch [atip_pkg::DEPTH];
	int          rec_yaw [atip_pkg::DEPTH];
	int          rec_count = 0;
	logic [31:0] next_time = 32'd1000;
	attitude_t   pending_attitudes[$];
	int          err_count = 0;
	bit          no_idle = 1'b0;

	function automatic logic signed [12:0] to_tenths(longint h);
		longint v;
		v = h / 10;
		if (v < -4096) v = -4096;
		if (v > 4095) v = 4095;
		return v[12:0];
	endfunction

	function automatic attitude_t record_attitude(int i);
		attitude_t a;
		a.roll = to_tenths(rec_roll[i]);
		a.pitch = to_tenths(rec_pitch[i]);
		a.yaw = to_tenths(rec_yaw[i]);
		a.status = atip_pkg::ST_OK;
		return a;
	endfunction

	function automatic longint lerp(int lo_v, int hi_v, longint dt, longint span);
		return longint'(lo_v) + (dt * (longint'(hi_v) - longint'(lo_v))) / span;
	endfunction

	function automatic attitude_t interpolate_attitude(logic o, logic [31:0] t,
			int r, int p, int y);
		attitude_t a;
		int lo, hi, mid;
		longint dt, span;
		a = '{0, 0, 0, atip_pkg::ST_OK};
		if (o == OP_LOAD) begin
			if (rec_count >= atip_pkg::DEPTH) begin
				a.status = atip_pkg::ST_FULL;
				return a;
			end
			rec_time[rec_count] = t;
			rec_roll[rec_count] = r;
			rec_pitch[rec_count] = p;
			rec_yaw[rec_count] = y;
			rec_count++;
			return a;
		end
		if (rec_count == 0) begin
			a.status = atip_pkg::ST_EMPTY;
			return a;
		end
		if (t <= rec_time[0]) return record_attitude(0);
		if (t >= rec_time[rec_count-1]) return record_attitude(rec_count - 1);
		lo = 0;
		hi = rec_count;
		while (lo < hi) begin
			mid = lo + (hi - lo) / 2;
			if (t < rec_time[mid]) hi = mid;
			else lo = mid + 1;
		end
		if (lo == 0) return record_attitude(0);
		if (lo >= rec_count) return record_attitude(rec_count - 1);
		// out-of-order neighbors: no interpolation
		if (!(rec_time[lo-1] <= t && t < rec_time[lo])) return record_attitude(lo - 1);
		dt = longint'(t) - longint'(rec_time[lo-1]);
		span = longint'(rec_time[lo]) - longint'(rec_time[lo-1]);
		a.roll = to_tenths(lerp(rec_roll[lo-1], rec_roll[lo], dt, span));
		a.pitch = to_tenths(lerp(rec_pitch[lo-1], rec_pitch[lo], dt, span));
		a.yaw = to_tenths(lerp(rec_yaw[lo-1], rec_yaw[lo], dt, span));
		return a;
	endfunction

	// called at a rising edge; returns at the edge that accepts the request
	task automatic send_request(logic o, logic [31:0] t, int r, int p, int y);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		op <= o;
		time_ms <= t;
		roll_in <= r[16:0];
		pitch_in <= p[16:0];
		yaw_in <= y[16:0];
		forever begin
			@(negedge clk);
			if (!busy) break;
		end
		@(posedge clk);
		pending_attitudes.insert(pending_attitudes.size(), interpolate_attitude(o, t, r, p, y));
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		while (pending_attitudes.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic int rand_angle();
		if ($urandom_range(0, 99) < 15) return $signed($urandom_range(0, 131071) - 65536);
		return $urandom_range(0, 72000) - 36000;
	endfunction

	task automatic load_ascending();
		send_request(OP_LOAD, next_time, rand_angle(), rand_angle(), rand_angle());
		case ($urandom_range(0, 9))
			0:       next_time += $urandom_range(0, 1 << 22);
			1:       next_time += 0;
			default: next_time += $urandom_range(1, 1000);
		endcase
	endtask

	function automatic logic [31:0] rand_query_time();
		int i, k;
		k = $urandom_range(0, 9);
		if (rec_count == 0 || k < 2) return $urandom;
		i = $urandom_range(0, rec_count - 1);
		if (k == 2) return rec_time[i];
		if (k == 3) return rec_time[0] - $urandom_range(0, 5);
		if (k == 4) return rec_time[rec_count-1] + $urandom_range(0, 5);
		if (i + 1 < rec_count && rec_time[i+1] > rec_time[i])
			return rec_time[i] + $urandom_range(0, rec_time[i+1] - rec_time[i] - 1);
		return rec_time[i];
	endfunction

	task automatic test_empty_table();
		send_request(OP_QUERY, 32'd0, 0, 0, 0);
		send_request(OP_QUERY, 32'hFFFF_FFFF, -65536, 65535, -1);
	endtask

	task automatic test_load_extremes();
		send_request(OP_LOAD, 32'd0, -65536, 65535, 0);
		send_request(OP_LOAD, 32'd100, 36000, -36000, 35999);
		send_request(OP_LOAD, 32'd100, -9, 9, 19);
		send_request(OP_LOAD, 32'd300, -36000, 36000, -19);
		send_request(OP_LOAD, 32'd200, 65535, -65536, 1234);  // out of order
		send_request(OP_LOAD, 32'd900, 0, 0, -36000);
	endtask

	task automatic test_query_cases();
		send_request(OP_QUERY, 32'd0, 0, 0, 0);
		send_request(OP_QUERY, 32'd1, 0, 0, 0);
		send_request(OP_QUERY, 32'd50, 0, 0, 0);
		send_request(OP_QUERY, 32'd99, 0, 0, 0);
		send_request(OP_QUERY, 32'd100, 0, 0, 0);
		send_request(OP_QUERY, 32'd150, 0, 0, 0);
		send_request(OP_QUERY, 32'd250, 0, 0, 0);
		send_request(OP_QUERY, 32'd450, 0, 0, 0);
		send_request(OP_QUERY, 32'd899, 0, 0, 0);
		send_request(OP_QUERY, 32'd900, 0, 0, 0);
		send_request(OP_QUERY, 32'hFFFF_FFFF, 0, 0, 0);
		send_request(OP_QUERY, 32'h8000_0000, 0, 0, 0);
	endtask

	task automatic test_random_mix(int n);
		for (int k = 0; k < n; k++) begin
			if (k % 64 == 0) no_idle = ($urandom_range(0, 3) == 0);
			case ($urandom_range(0, 19))
				0:             send_request(OP_LOAD, $urandom, rand_angle(), rand_angle(),
					rand_angle());
				1, 2, 3, 4, 5, 6, 7, 8, 9, 10:
					load_ascending();
				default:       send_request(OP_QUERY, rand_query_time(), rand_angle(),
					rand_angle(), rand_angle());
			endcase
		end
		no_idle = 1'b0;
	endtask

	task automatic test_full_table();
		while (rec_count < atip_pkg::DEPTH) load_ascending();
		repeat (6) begin
			send_request(OP_LOAD, $urandom, rand_angle(), rand_angle(), rand_angle());
			send_request(OP_QUERY, rand_query_time(), 0, 0, 0);
		end
	endtask

	always @(negedge clk) begin
		attitude_t e;
		if (arst_n && strobe) begin
			if (pending_attitudes.size() == 0) begin
				$error("unexpected result strobe");
				err_count++;
			end else begin
				e = pending_attitudes.pop_front();
				if (roll_ddeg !== e.roll) begin
					$error("roll_ddeg: expected %0d, got %0d", e.roll, roll_ddeg);
					err_count++;
				end
				if (pitch_ddeg !== e.pitch) begin
					$error("pitch_ddeg: expected %0d, got %0d", e.pitch, pitch_ddeg);
					err_count++;
				end
				if (yaw_ddeg !== e.yaw) begin
					$error("yaw_ddeg: expected %0d, got %0d", e.yaw, yaw_ddeg);
					err_count++;
				end
				if (status !== e.status) begin
					$error("status: expected %0d, got %0d", e.status, status);
					err_count++;
				end
			end
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_table();
		test_load_extremes();
		test_query_cases();
		test_random_mix(500);
		wait_drained();
		test_random_mix(500);
		test_full_table();
		wait_drained();
		repeat (200) @(posedge clk);
		if (err_count == 0 && pending_attitudes.size() == 0)
			$display("attitude_time_interpolator regression: pass");
		else
			$display("attitude_time_interpolator regression: fail");
		$finish;
	end

	initial begin
		#20ms;
		$display("attitude_time_interpolator regression: fail");
		$finish;
	end
endmodule
`default_nettype wire

[filelist.f]
rtl/atip_pkg.sv
rtl/atip_div.sv
rtl/atip_dp.sv
rtl/atip_ctrl.sv
rtl/attitude_time_interpolator.sv
bench/tb.sv
